[design/websocket_frame_deframer_core_assert.svh]
// Assertion macros shared by the deframer RTL.
// Included by websocket_frame_deframer_core.sv; no other dependencies.
`ifndef WEBSOCKET_FRAME_DEFRAMER_CORE_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WSFD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deframer assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define WSFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deframer assertion failed");

`endif

[design/wsfd_pkg.sv]
// Package for the WebSocket frame deframer: parse phase codes, header constants
// and the result and status structs. No dependencies.
`timescale 1ns / 1ps

package wsfd_pkg;

   localparam logic [2:0] PH_HDR0  = 3'd0;
   localparam logic [2:0] PH_HDR1  = 3'd1;
   localparam logic [2:0] PH_EXT16 = 3'd2;
   localparam logic [2:0] PH_EXT64 = 3'd3;
   localparam logic [2:0] PH_KEY   = 3'd4;
   localparam logic [2:0] PH_DATA  = 3'd5;

   localparam logic [3:0] OPC_CONTINUATION = 4'h0;
   localparam logic [6:0] LEN_EXT16        = 7'd126;
   localparam logic [6:0] LEN_EXT64        = 7'd127;
   localparam logic [2:0] EXT16_LAST       = 3'd1;
   localparam logic [2:0] EXT64_LAST       = 3'd7;
   localparam logic [2:0] KEY_LAST         = 3'd3;

   localparam logic CSR_IDX_UNMASK = 1'b0;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       byte_valid;
      logic [3:0] frame_opcode;
      logic [3:0] message_opcode;
      logic       frame_fin;
      logic       frame_masked;
      logic       frame_end;
      logic       message_end;
   } rsp_item_type;

   typedef struct packed {
      logic       emit;
      logic [2:0] phase;
   } parse_status_type;

endpackage

[design/wsfd_parser.sv]
// Header parser and payload unmasker of the WebSocket frame deframer.
// Depends on wsfd_pkg; one stream byte is consumed per accepted request.
`timescale 1ns / 1ps

module wsfd_parser
   import wsfd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       rx_byte,
   input  logic             unmask_enable,
   output parse_status_type status,
   output rsp_item_type     item
);

   logic [2:0]  phase_ff, phase_in;
   logic        fin_ff, fin_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        masked_ff, masked_in;
   logic [3:0]  resolved_ff, resolved_in;
   logic [3:0]  pending_ff, pending_in;
   logic [2:0]  count_ff, count_in;
   logic [63:0] remaining_ff, remaining_in;
   logic [31:0] key_ff, key_in;
   logic [1:0]  position_ff, position_in;

   logic        emit;
   logic        data_valid;
   logic        frame_end;
   logic [7:0]  data_byte;
   logic [7:0]  key_byte;
   logic [6:0]  len7;
   logic [2:0]  ext_last;

   assign len7     = rx_byte[6:0];
   assign ext_last = (phase_ff == PH_EXT16) ? EXT16_LAST : EXT64_LAST;

   always_comb begin
      case (position_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   always_comb begin
      phase_in     = phase_ff;
      fin_in       = fin_ff;
      opcode_in    = opcode_ff;
      masked_in    = masked_ff;
      resolved_in  = resolved_ff;
      pending_in   = pending_ff;
      count_in     = count_ff;
      remaining_in = remaining_ff;
      key_in       = key_ff;
      position_in  = position_ff;
      emit         = 1'b0;
      data_valid   = 1'b0;
      frame_end    = 1'b0;
      data_byte    = 8'h00;
      case (phase_ff)
         PH_HDR0: begin
            fin_in    = rx_byte[7];
            opcode_in = rx_byte[3:0];
            resolved_in = (rx_byte[3:0] == OPC_CONTINUATION) ? pending_ff : rx_byte[3:0];
            if (!rx_byte[7] && rx_byte[3:0] != OPC_CONTINUATION) begin
               pending_in = rx_byte[3:0];
            end
            phase_in = PH_HDR1;
         end
         PH_HDR1: begin
            masked_in = rx_byte[7];
            count_in  = 3'd0;
            case (len7)
               LEN_EXT16: begin
                  remaining_in = 64'd0;
                  phase_in     = PH_EXT16;
               end
               LEN_EXT64: begin
                  remaining_in = 64'd0;
                  phase_in     = PH_EXT64;
               end
               default: begin
                  remaining_in = {57'd0, len7};
                  if (rx_byte[7]) begin
                     key_in   = 32'd0;
                     phase_in = PH_KEY;
                  end else begin
                     position_in = 2'd0;
                     if (len7 == 7'd0) begin
                        emit      = 1'b1;
                        frame_end = 1'b1;
                        phase_in  = PH_HDR0;
                     end else begin
                        phase_in = PH_DATA;
                     end
                  end
               end
            endcase
         end
         PH_EXT16, PH_EXT64: begin
            remaining_in = {remaining_ff[55:0], rx_byte};
            if (count_ff == ext_last) begin
               count_in = 3'd0;
               if (masked_ff) begin
                  key_in   = 32'd0;
                  phase_in = PH_KEY;
               end else begin
                  position_in = 2'd0;
                  if (remaining_in == 64'd0) begin
                     emit      = 1'b1;
                     frame_end = 1'b1;
                     phase_in  = PH_HDR0;
                  end else begin
                     phase_in = PH_DATA;
                  end
               end
            end else begin
               count_in = count_ff + 3'd1;
            end
         end
         PH_KEY: begin
            key_in = {key_ff[23:0], rx_byte};
            if (count_ff == KEY_LAST) begin
               count_in    = 3'd0;
               position_in = 2'd0;
               if (remaining_ff == 64'd0) begin
                  emit      = 1'b1;
                  frame_end = 1'b1;
                  phase_in  = PH_HDR0;
               end else begin
                  phase_in = PH_DATA;
               end
            end else begin
               count_in = count_ff + 3'd1;
            end
         end
         PH_DATA: begin
            data_byte    = (masked_ff && unmask_enable) ? (rx_byte ^ key_byte) : rx_byte;
            data_valid   = 1'b1;
            emit         = 1'b1;
            position_in  = position_ff + 2'd1;
            remaining_in = remaining_ff - 64'd1;
            frame_end    = (remaining_ff == 64'd1);
            if (remaining_ff == 64'd1) begin
               phase_in = PH_HDR0;
            end
         end
         default: begin
            phase_in = PH_HDR0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HDR0;
         fin_ff      <= 1'b0;
         opcode_ff   <= 4'd0;
         masked_ff   <= 1'b0;
         resolved_ff <= 4'd0;
         pending_ff  <= 4'd0;
         count_ff    <= 3'd0;
         position_ff <= 2'd0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         fin_ff      <= fin_in;
         opcode_ff   <= opcode_in;
         masked_ff   <= masked_in;
         resolved_ff <= resolved_in;
         pending_ff  <= pending_in;
         count_ff    <= count_in;
         position_ff <= position_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         remaining_ff <= remaining_in;
         key_ff       <= key_in;
      end
   end

   assign status.emit  = emit;
   assign status.phase = phase_ff;

   assign item.payload_byte   = data_byte;
   assign item.byte_valid     = data_valid;
   assign item.frame_opcode   = opcode_ff;
   assign item.message_opcode = resolved_ff;
   assign item.frame_fin      = fin_ff;
   assign item.frame_masked   = masked_in;
   assign item.frame_end      = frame_end;
   assign item.message_end    = frame_end & fin_ff;

endmodule

[design/websocket_frame_deframer_core.sv]
// Channel  | Direction | Contents
// req      | in        | one raw stream byte per request
// rsp      | out       | one payload byte or zero-length frame marker per request
// csr      | in/out    | APB register: unmask_enable at byte address 0
//
// One request is accepted every cycle unless a held result waits on rsp_tready; the
// header parser state updates at acceptance. A result is held in the output register.
// Only payload bytes and an empty frame's last header byte give a result, next cycle.
// Reset is synchronous: parser returns to the frame header, unmask_enable becomes 1.
// Depends on wsfd_pkg, wsfd_parser and the assertion macro header.
`timescale 1ns / 1ps
`include "websocket_frame_deframer_core_assert.svh"

module websocket_frame_deframer_core
   import wsfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,     // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,     // [7:0] payload_byte, [11:8] frame_opcode,
                                      // [15:12] message_opcode, [16] frame_fin,
                                      // [17] frame_masked, [18] message_end, rest zero
   output logic        rsp_tlast,     // frame_end
   output logic        rsp_tuser,     // byte_valid
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic             unmask_ff, unmask_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_item_type     rsp_item_ff;
   rsp_item_type     parse_item;
   parse_status_type parse_status;
   logic             accept;
   logic             csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign unmask_in  = (csr_write && csr_paddr[2] == CSR_IDX_UNMASK) ? csr_pwdata[0]
                                                                      : unmask_ff;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_UNMASK) ? {31'd0, unmask_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         unmask_ff <= 1'b1;
      end else begin
         unmask_ff <= unmask_in;
      end
   end

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   wsfd_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .rx_byte       (req_tdata),
      .unmask_enable (unmask_ff),
      .status        (parse_status),
      .item          (parse_item)
   );

   assign rsp_valid_in = accept ? parse_status.emit : (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && parse_status.emit) begin
         rsp_item_ff <= parse_item;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_item_ff.message_end, rsp_item_ff.frame_masked,
                        rsp_item_ff.frame_fin, rsp_item_ff.message_opcode,
                        rsp_item_ff.frame_opcode, rsp_item_ff.payload_byte};
   assign rsp_tlast  = rsp_item_ff.frame_end;
   assign rsp_tuser  = rsp_item_ff.byte_valid;

   `WSFD_ASSERT_SAME(a_msg_end_is_frame_end, clock, reset,
      rsp_tvalid && rsp_item_ff.message_end, rsp_tlast)
   `WSFD_ASSERT_SAME(a_marker_is_empty_end, clock, reset,
      rsp_tvalid && !rsp_tuser, rsp_tlast && rsp_item_ff.payload_byte == 8'h00)
   `WSFD_ASSERT_NEXT(a_hdr0_goes_hdr1, clock, reset,
      accept && parse_status.phase == PH_HDR0, parse_status.phase == PH_HDR1)
   `WSFD_ASSERT_NEXT(a_emit_loads_output, clock, reset,
      accept && parse_status.emit, rsp_tvalid)

endmodule
